// ===== src/rtac_pkg.sv =====
// shared types, constants and helpers of the rgb to argb texel converter
package rtac_pkg;

    localparam int CHAN_W  = 8;
    localparam int TEXEL_W = 32;
    localparam int PROD_W  = 2 * CHAN_W;
    localparam int WSUM_W  = CHAN_W + 2;
    localparam int CSUM_W  = PROD_W + 2;
    localparam int NUM_W   = CSUM_W + CHAN_W;
    localparam int REM_W   = NUM_W - CHAN_W;
    localparam int QUOT_W  = 8;
    localparam int WIDE_SHIFT   = 8;
    localparam int NARROW_SHIFT = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NARROW_FORMAT = 3'd0,
        CFG_ALPHA_SOURCE  = 3'd1,
        CFG_FIXED_ALPHA   = 3'd2,
        CFG_WEIGHT_RED    = 3'd3,
        CFG_WEIGHT_GREEN  = 3'd4,
        CFG_WEIGHT_BLUE   = 3'd5,
        CFG_WEIGHT_ALPHA  = 3'd6
    } t_cfg_index;

    localparam logic [1:0] ASRC_FIXED    = 2'd0;
    localparam logic [1:0] ASRC_WEIGHTED = 2'd1;
    localparam logic [1:0] ASRC_PLANE    = 2'd2;

    localparam logic [CHAN_W-1:0] FIXED_ALPHA_RESET = 8'hFF;
    localparam logic [3:0]        OPAQUE_NIBBLE     = 4'hF;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] plane_alpha;
    } t_in_data;

    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic               zero_weights;
    } t_out_data;

    function automatic logic [TEXEL_W-1:0] pack_4444(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        return {16'h0000, a[7:4], r[7:4], g[7:4], b[7:4]};
    endfunction

    function automatic logic [TEXEL_W-1:0] pack_1555(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        return {16'h0000, 1'b1, r[7:3], g[7:3], b[7:3]};
    endfunction

endpackage

// ===== src/rgb_to_argb_texel_converter.sv =====
// top level of the rgb to argb texel converter: weighted alpha pipeline and texel packing
// Takes one pixel per cycle and gives one texel per cycle while the output is not
// stalled. A pixel passes twelve register stages on its way to the output: three
// stages of weighted-sum arithmetic (colour products, their sum, the alpha scale), an
// eight-stage restoring divider that yields one alpha bit per stage, and the output
// register. Bubbles collapse, so a stall at the output only holds the input once every
// stage is full. Configuration writes are always taken and must only be made while no
// transaction is in flight.
module rgb_to_argb_texel_converter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rtac_pkg::t_in_data          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rtac_pkg::t_out_data         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rtac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtac_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rtac_pkg::*;

    localparam int DIV_FIRST = 3;
    localparam int OUT_STG   = DIV_FIRST + QUOT_W;
    localparam int NSTG      = OUT_STG + 1;

    typedef struct packed {
        logic [TEXEL_W-1:0] base;
        logic               weighted;
        logic               narrow;
        logic               zero;
    } t_carry;

    // configuration registers
    logic              r_narrow;
    logic [1:0]        r_asrc;
    logic [CHAN_W-1:0] r_fixed_alpha;
    logic [CHAN_W-1:0] r_wr;
    logic [CHAN_W-1:0] r_wg;
    logic [CHAN_W-1:0] r_wb;
    logic [CHAN_W-1:0] r_wa;

    // pipeline registers
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   en;

    t_carry            r_s1_carry;
    logic [PROD_W-1:0] r_s1_pr;
    logic [PROD_W-1:0] r_s1_pg;
    logic [PROD_W-1:0] r_s1_pb;
    logic [WSUM_W-1:0] r_s1_wsum;

    t_carry            r_s2_carry;
    logic [CSUM_W-1:0] r_s2_sum;
    logic [WSUM_W-1:0] r_s2_wsum;

    t_carry            r_s3_carry;
    logic [REM_W-1:0]  r_s3_rem;
    logic [WSUM_W-1:0] r_s3_wsum;

    t_carry            r_dv_carry [QUOT_W];
    logic [REM_W-1:0]  r_dv_rem   [QUOT_W];
    logic [QUOT_W-1:0] r_dv_q     [QUOT_W];
    logic [WSUM_W-1:0] r_dv_wsum  [QUOT_W];

    t_out_data         r_out;

    t_carry            n_s1_carry;
    logic [NUM_W-1:0]  n_num;
    logic [REM_W-1:0]  n_s3_rem;
    logic [REM_W-1:0]  n_dv_rem [QUOT_W];
    logic [QUOT_W-1:0] n_dv_q   [QUOT_W];
    t_out_data         n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow      <= 1'b0;
            r_asrc        <= ASRC_FIXED;
            r_fixed_alpha <= FIXED_ALPHA_RESET;
            r_wr          <= '0;
            r_wg          <= '0;
            r_wb          <= '0;
            r_wa          <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NARROW_FORMAT: r_narrow      <= i_cfg_data[0];
                CFG_ALPHA_SOURCE:  r_asrc        <= i_cfg_data[1:0];
                CFG_FIXED_ALPHA:   r_fixed_alpha <= i_cfg_data;
                CFG_WEIGHT_RED:    r_wr          <= i_cfg_data;
                CFG_WEIGHT_GREEN:  r_wg          <= i_cfg_data;
                CFG_WEIGHT_BLUE:   r_wb          <= i_cfg_data;
                CFG_WEIGHT_ALPHA:  r_wa          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables, a stage moves when empty or when the next one moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // base texel without weighted alpha
    always_comb begin
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] p;
        r = i_in_data.red;
        g = i_in_data.green;
        b = i_in_data.blue;
        p = i_in_data.plane_alpha;
        n_s1_carry.narrow   = r_narrow;
        n_s1_carry.weighted = (r_asrc == ASRC_WEIGHTED);
        n_s1_carry.zero     = ({2'b00, r_wr} + {2'b00, r_wg} + {2'b00, r_wb}) == '0;
        priority if (r_asrc == ASRC_WEIGHTED) begin
            n_s1_carry.base = r_narrow ? pack_4444('0, r, g, b) : {8'h00, r, g, b};
        end else if (r_asrc == ASRC_PLANE) begin
            n_s1_carry.base = r_narrow ? pack_4444(p, r, g, b) : {p, r, g, b};
        end else if (!r_narrow) begin
            n_s1_carry.base = {r_fixed_alpha, r, g, b};
        end else if (r_fixed_alpha[7:4] == OPAQUE_NIBBLE) begin
            n_s1_carry.base = pack_1555(r, g, b);
        end else begin
            n_s1_carry.base = pack_4444(r_fixed_alpha, r, g, b);
        end
    end

    always_comb begin
        n_num = {{(NUM_W-CSUM_W){1'b0}}, r_s2_sum} * {{(NUM_W-CHAN_W){1'b0}}, r_wa};
        if (r_s2_carry.narrow) begin
            n_s3_rem = REM_W'(n_num >> NARROW_SHIFT);
        end else begin
            n_s3_rem = REM_W'(n_num >> WIDE_SHIFT);
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] q_in;
        logic [REM_W-1:0]  dvs;
        logic              ge;
        rem_in      = r_s3_rem;
        q_in        = '0;
        dvs         = REM_W'(r_s3_wsum) << (QUOT_W - 1);
        ge          = (rem_in >= dvs);
        n_dv_rem[0] = ge ? (rem_in - dvs) : rem_in;
        n_dv_q[0]   = {q_in[QUOT_W-2:0], ge};
        for (int j = 1; j < QUOT_W; j++) begin
            rem_in      = r_dv_rem[j-1];
            q_in        = r_dv_q[j-1];
            dvs         = REM_W'(r_dv_wsum[j-1]) << (QUOT_W - 1 - j);
            ge          = (rem_in >= dvs);
            n_dv_rem[j] = ge ? (rem_in - dvs) : rem_in;
            n_dv_q[j]   = {q_in[QUOT_W-2:0], ge};
        end
    end

    always_comb begin
        t_carry            c;
        logic [QUOT_W-1:0] q;
        c = r_dv_carry[QUOT_W-1];
        q = r_dv_q[QUOT_W-1];
        n_out.texel        = c.base;
        n_out.zero_weights = c.weighted && c.zero;
        if (c.weighted && !c.zero) begin
            if (c.narrow) begin
                n_out.texel = c.base | {16'h0000, q[3:0], 12'h000};
            end else begin
                n_out.texel = c.base | {q, 24'h000000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_carry <= n_s1_carry;
            r_s1_pr    <= {8'h00, i_in_data.red} * {8'h00, r_wr};
            r_s1_pg    <= {8'h00, i_in_data.green} * {8'h00, r_wg};
            r_s1_pb    <= {8'h00, i_in_data.blue} * {8'h00, r_wb};
            r_s1_wsum  <= {2'b00, r_wr} + {2'b00, r_wg} + {2'b00, r_wb};
        end
        if (en[1]) begin
            r_s2_carry <= r_s1_carry;
            r_s2_sum   <= {2'b00, r_s1_pr} + {2'b00, r_s1_pg} + {2'b00, r_s1_pb};
            r_s2_wsum  <= r_s1_wsum;
        end
        if (en[2]) begin
            r_s3_carry <= r_s2_carry;
            r_s3_rem   <= n_s3_rem;
            r_s3_wsum  <= r_s2_wsum;
        end
        if (en[DIV_FIRST]) begin
            r_dv_carry[0] <= r_s3_carry;
            r_dv_wsum[0]  <= r_s3_wsum;
            r_dv_rem[0]   <= n_dv_rem[0];
            r_dv_q[0]     <= n_dv_q[0];
        end
        for (int j = 1; j < QUOT_W; j++) begin
            if (en[DIV_FIRST+j]) begin
                r_dv_carry[j] <= r_dv_carry[j-1];
                r_dv_wsum[j]  <= r_dv_wsum[j-1];
                r_dv_rem[j]   <= n_dv_rem[j];
                r_dv_q[j]     <= n_dv_q[j];
            end
        end
        if (en[OUT_STG]) begin
            r_out <= n_out;
        end
    end

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld) && i_out_stall)
        else $error("input stalled while the pipeline has room");

    a_zero_weights_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_weights && !r_narrow |->
            o_out_data.texel[31:24] == '0)
        else $error("zero weights transaction carries a nonzero wide alpha");

    a_narrow_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_narrow |-> o_out_data.texel[31:16] == '0)
        else $error("narrow texel has a nonzero upper half");

    a_flag_needs_weighted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_weights |-> r_asrc == ASRC_WEIGHTED)
        else $error("zero weights flag set without the weighted alpha source");

endmodule
